// File: src/fstimer_pkg.sv
`default_nettype none

package fstimer_pkg;

    localparam int unsigned TIME_W           = 48;
    localparam int unsigned ACC_W            = 20;
    localparam int unsigned SUM_W            = ACC_W + 1;
    localparam int unsigned PERIOD_W         = 20;
    localparam int unsigned TARGET_W         = 40;
    localparam int unsigned COUNT_W          = 10;
    localparam int unsigned FRAMES_W         = 16;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 40;

    localparam logic [ACC_W-1:0]    TICKS_PER_SECOND = ACC_W'(1000000);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD       = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] RST_PERIOD       = PERIOD_W'(16667);
    localparam logic [TARGET_W-1:0] RST_TARGET       = TARGET_W'(1000000);

    // one quotient bit per step over the whole sum-width dividend
    localparam int unsigned DIV_STEPS = SUM_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC     = CFG_IDX_W'(3);

    typedef struct packed {
        logic load;      // latch the accepted timestamp
        logic calc;      // delta, accumulator, variable-mode update
        logic div_step;  // one restoring-division step
        logic fin;       // frame count, target check, output load
    } t_cmd;

    typedef struct packed {
        logic active;
        logic fixed_mode;
    } t_status;

endpackage

`default_nettype wire

// File: src/fstimer_ctrl.sv
`default_nettype none

module fstimer_ctrl
    import fstimer_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    logic               out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_step     = '0;
                // fixed mode divides; variable or inactive goes straight on
                n_state    = (i_status.active && i_status.fixed_mode) ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_div_only_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> i_status.fixed_mode && i_status.active)
        else $error("division running outside active fixed mode");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_step <= STEP_W'(DIV_STEPS - 1))
        else $error("division step counter overran");

    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && !out_free |=> r_state == S_FIN && r_out_valid)
        else $error("result dropped while output slot busy");

endmodule

`default_nettype wire

// File: src/fstimer_dp.sv
`default_nettype none

module fstimer_dp
    import fstimer_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  wire  [TIME_W-1:0]      i_timestamp,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_started,
    output logic [COUNT_W-1:0]     o_update_count,
    output logic                   o_destination_reached,
    output logic [TIME_W-1:0]      o_raw_delta,
    output logic [FRAMES_W-1:0]    o_frames_in_period,
    output logic                   o_is_active
);

    // configuration
    logic                 r_fixed_mode;
    logic [PERIOD_W-1:0]  r_period_cfg;
    logic [TARGET_W-1:0]  r_target;
    logic                 r_cyclic;

    // timer state
    logic [TIME_W-1:0]    r_last_time;
    logic [TIME_W-1:0]    r_start_time;
    logic [ACC_W-1:0]     r_acc;
    logic [FRAMES_W-1:0]  r_frames;
    logic                 r_active;
    logic                 r_first;

    // per-frame working registers
    logic [TIME_W-1:0]    r_ts;
    logic [TIME_W-1:0]    r_delta;
    logic                 r_started;
    logic                 r_vcount;
    logic [SUM_W-1:0]     r_dividend;
    logic [ACC_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_quot;

    // output register
    logic                 r_o_started;
    logic [COUNT_W-1:0]   r_o_count;
    logic                 r_o_reached;
    logic [TIME_W-1:0]    r_o_delta;
    logic [FRAMES_W-1:0]  r_o_frames;
    logic                 r_o_active;

    logic [PERIOD_W-1:0]  period;
    logic [TIME_W-1:0]    base_time;
    logic [TIME_W-1:0]    delta;
    logic [ACC_W-1:0]     delta_cap;
    logic [SUM_W-1:0]     sum;
    logic [ACC_W-1:0]     acc_new;
    logic [SUM_W-1:0]     rem_shift;
    logic                 rem_fits;
    logic [COUNT_W-1:0]   count;
    logic [FRAMES_W-1:0]  frames_new;
    logic [TIME_W-1:0]    elapsed;
    logic                 reached;

    assign o_status.active     = r_active;
    assign o_status.fixed_mode = r_fixed_mode;

    assign period    = (r_period_cfg < MIN_PERIOD) ? MIN_PERIOD : r_period_cfg;
    assign base_time = r_first ? r_ts : r_last_time;
    assign delta     = r_ts - base_time;
    assign delta_cap = (delta < TIME_W'(TICKS_PER_SECOND)) ? delta[ACC_W-1:0]
                                                           : TICKS_PER_SECOND;
    assign sum       = {1'b0, r_acc} + {1'b0, delta_cap};
    // clear once a full second has piled up
    assign acc_new   = (sum >= SUM_W'(TICKS_PER_SECOND)) ? '0 : sum[ACC_W-1:0];

    assign rem_shift = {r_rem, r_dividend[SUM_W-1]};
    assign rem_fits  = rem_shift >= SUM_W'(period);

    assign count      = r_fixed_mode ? r_quot[COUNT_W-1:0] : COUNT_W'(r_vcount);
    assign frames_new = r_frames + FRAMES_W'(count);
    assign elapsed    = r_ts - r_start_time;
    assign reached    = elapsed >= TIME_W'(r_target);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_mode <= 1'b1;
            r_period_cfg <= RST_PERIOD;
            r_target     <= RST_TARGET;
            r_cyclic     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIXED_MODE: r_fixed_mode <= i_cfg_data[0];
                CFG_PERIOD:     r_period_cfg <= i_cfg_data[PERIOD_W-1:0];
                CFG_TARGET:     r_target     <= i_cfg_data[TARGET_W-1:0];
                CFG_CYCLIC:     r_cyclic     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_start_time <= '0;
            r_acc        <= '0;
            r_frames     <= '0;
            r_active     <= 1'b1;
            r_first      <= 1'b1;
        end else begin
            if (i_cmd.calc && r_active) begin
                r_first     <= 1'b0;
                r_last_time <= r_ts;
                if (r_first) begin
                    r_start_time <= r_ts;
                end
                // variable mode: at most one update, then drop the remainder
                if (!r_fixed_mode && acc_new >= period) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= acc_new;
                end
            end
            if (i_cmd.fin && r_active) begin
                if (r_fixed_mode) begin
                    r_acc <= r_rem;
                end
                if (reached) begin
                    r_start_time <= r_ts;
                    r_frames     <= '0;
                    r_active     <= r_cyclic;
                end else begin
                    r_frames <= frames_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ts <= i_timestamp;
        end
        if (i_cmd.calc) begin
            r_started  <= r_first;
            r_delta    <= delta;
            r_vcount   <= acc_new >= period;
            r_dividend <= SUM_W'(acc_new);
            r_rem      <= '0;
            r_quot     <= '0;
        end
        if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[SUM_W-2:0], 1'b0};
            r_quot     <= {r_quot[SUM_W-2:0], rem_fits};
            r_rem      <= rem_fits ? ACC_W'(rem_shift - SUM_W'(period))
                                   : rem_shift[ACC_W-1:0];
        end
        if (i_cmd.fin) begin
            if (r_active) begin
                r_o_started <= r_started;
                r_o_count   <= count;
                r_o_reached <= reached;
                r_o_delta   <= r_delta;
                r_o_frames  <= frames_new;
                r_o_active  <= reached ? r_cyclic : 1'b1;
            end else begin
                r_o_started <= 1'b0;
                r_o_count   <= '0;
                r_o_reached <= 1'b0;
                r_o_delta   <= '0;
                r_o_frames  <= r_frames;
                r_o_active  <= 1'b0;
            end
        end
    end

    assign o_started             = r_o_started;
    assign o_update_count        = r_o_count;
    assign o_destination_reached = r_o_reached;
    assign o_raw_delta           = r_o_delta;
    assign o_frames_in_period    = r_o_frames;
    assign o_is_active           = r_o_active;

    a_acc_below_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < TICKS_PER_SECOND)
        else $error("update accumulator reached one second");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin && r_active && r_fixed_mode |-> r_quot[SUM_W-1:COUNT_W] == '0)
        else $error("update count exceeds its field");

    a_inactive_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active && !i_cfg_we |=> !r_active && $stable(r_frames) && $stable(r_acc))
        else $error("inactive timer changed state");

endmodule

`default_nettype wire

// File: src/fixed_timestep_frame_timer.sv
// From request acceptance to result valid, fixed mode runs calc, 21 restoring-division
//   steps and finish; variable mode or an inactive timer runs calc and finish only.
// One request at a time: a new request is taken only once the last one has finished,
//   and a held result stalls only the finish step.
// Reset (synchronous, active low): timer active and waiting for its first frame,
//   all times, accumulator and frame count zero, registers at their defaults.
`default_nettype none

module fixed_timestep_frame_timer
    import fstimer_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // frame-start request channel
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire  [TIME_W-1:0]      i_timestamp,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic                   o_started,
    output logic [COUNT_W-1:0]     o_update_count,
    output logic                   o_destination_reached,
    output logic [TIME_W-1:0]      o_raw_delta,
    output logic [FRAMES_W-1:0]    o_frames_in_period,
    output logic                   o_is_active,
    // configuration write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Register writes always land, so the write channel never stalls.
    assign o_cfg_ready = 1'b1;

    // Controller: sequences one request through calc, divide (fixed mode only) and
    // finish, and owns both handshakes plus the output-valid flag.
    fstimer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: timer state, configuration registers, the restoring divider
    // that splits the accumulator into updates and remainder, and the
    // result register that holds while the consumer stalls.
    fstimer_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_timestamp           (i_timestamp),
        .i_cfg_we              (i_cfg_valid),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_started             (o_started),
        .o_update_count        (o_update_count),
        .o_destination_reached (o_destination_reached),
        .o_raw_delta           (o_raw_delta),
        .o_frames_in_period    (o_frames_in_period),
        .o_is_active           (o_is_active)
    );

endmodule

`default_nettype wire

// File: tb/fixed_timestep_frame_timer_tb.sv
`timescale 1ns / 1ps

module fixed_timestep_frame_timer_tb;
    import fstimer_pkg::*;

    localparam int unsigned ONE_SECOND  = 1000000;
    localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off for back-pressure
    localparam int unsigned DRAIN_WAIT  = 40;    // a little over the fixed-mode latency
    localparam int unsigned STALL_LIMIT = 3000;  // cycles with no handshake at all

    // One result as the block reports it.
    typedef struct packed {
        logic                started;
        logic [COUNT_W-1:0]  update_count;
        logic                reached;
        logic [TIME_W-1:0]   raw_delta;
        logic [FRAMES_W-1:0] frames;
        logic                is_active;
    } t_frame_result;

    // Block ports; every input is known from time zero.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [TIME_W-1:0]     i_timestamp = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_started;
    logic [COUNT_W-1:0]    o_update_count;
    logic                  o_destination_reached;
    logic [TIME_W-1:0]     o_raw_delta;
    logic [FRAMES_W-1:0]   o_frames_in_period;
    logic                  o_is_active;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shadow copy of the registers, at their reset values.
    logic                  reg_fixed  = 1'b1;
    logic [PERIOD_W-1:0]   reg_period = RST_PERIOD;
    logic [TARGET_W-1:0]   reg_target = RST_TARGET;
    logic                  reg_cyclic = 1'b1;

    // Shadow copy of the timer state.
    logic [TIME_W-1:0]     tmr_last   = '0;
    logic [TIME_W-1:0]     tmr_start  = '0;
    logic [ACC_W-1:0]      tmr_acc    = '0;
    logic [FRAMES_W-1:0]   tmr_frames = '0;
    logic                  tmr_active = 1'b1;
    logic                  tmr_first  = 1'b1;

    t_frame_result         expected_frames[$];
    logic [TIME_W-1:0]     ts_now       = '0;
    int unsigned           mismatches   = 0;
    logic                  idle_off     = 1'b0;  // both sides run without gaps
    int unsigned           pressure_req = 0;     // bump to start a long hold-off
    int unsigned           pressure_ack = 0;
    int unsigned           hold_left    = 0;
    int unsigned           ready_wait   = 0;
    int unsigned           quiet_cycles = 0;

    fixed_timestep_frame_timer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_timestamp           (i_timestamp),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_started             (o_started),
        .o_update_count        (o_update_count),
        .o_destination_reached (o_destination_reached),
        .o_raw_delta           (o_raw_delta),
        .o_frames_in_period    (o_frames_in_period),
        .o_is_active           (o_is_active),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame timer prediction: advance the shadow state by one frame-start
    // request and return the result the block must give for it.
    // ------------------------------------------------------------------
    function automatic t_frame_result predict_frame(input logic [TIME_W-1:0] ts);
        t_frame_result       r;
        logic [TIME_W-1:0]   delta;
        logic [TIME_W-1:0]   elapsed;
        logic [SUM_W-1:0]    sum;
        logic [PERIOD_W-1:0] period;
        logic [ACC_W-1:0]    q;
        r = '0;
        // an inactive timer freezes and only reports its frame count
        if (!tmr_active) begin
            r.frames = tmr_frames;
            return r;
        end
        // first frame: anchor both times so the delta comes out zero
        if (tmr_first) begin
            tmr_first = 1'b0;
            r.started = 1'b1;
            tmr_start = ts;
            tmr_last  = ts;
        end
        delta    = ts - tmr_last;   // wraps when time runs backwards
        tmr_last = ts;
        // cap the delta at one second; a full second clears the accumulator
        sum = SUM_W'(tmr_acc)
              + ((delta < TIME_W'(ONE_SECOND)) ? delta[SUM_W-1:0] : SUM_W'(ONE_SECOND));
        tmr_acc = (sum >= SUM_W'(ONE_SECOND)) ? '0 : sum[ACC_W-1:0];
        period = (reg_period < MIN_PERIOD) ? MIN_PERIOD : reg_period;
        q = '0;
        if (reg_fixed) begin
            q       = tmr_acc / period;
            tmr_acc = tmr_acc % period;
        end else if (tmr_acc >= period) begin
            q       = ACC_W'(1);
            tmr_acc = '0;
        end
        tmr_frames     = tmr_frames + q[FRAMES_W-1:0];
        r.update_count = q[COUNT_W-1:0];
        r.raw_delta    = delta;
        r.frames       = tmr_frames;   // reported before any restart
        elapsed = ts - tmr_start;
        if (elapsed >= {{(TIME_W-TARGET_W){1'b0}}, reg_target}) begin
            r.reached  = 1'b1;
            tmr_start  = ts;
            tmr_frames = '0;
            tmr_active = reg_cyclic;
        end
        r.is_active = tmr_active;
        return r;
    endfunction

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    // Next timestamp of a random run: mostly steps around the update period,
    // with longer steps, repeats, backward jumps and wild values mixed in.
    function automatic logic [TIME_W-1:0] next_timestamp();
        int unsigned         pick;
        logic [PERIOD_W-1:0] per;
        per  = (reg_period < MIN_PERIOD) ? MIN_PERIOD : reg_period;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return ts_now + TIME_W'($urandom_range(0, 2 * per));
        else if (pick < 85)
            return ts_now + TIME_W'($urandom_range(0, 1500000));
        else if (pick < 90)
            return ts_now;
        else if (pick < 95)
            return ts_now - TIME_W'($urandom_range(1, 100000));
        else
            return rand48();
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("result with no request pending", o_raw_delta, '0);
            end else begin
                want = expected_frames.pop_front();
                check_field("started", TIME_W'(o_started), TIME_W'(want.started));
                check_field("update_count", TIME_W'(o_update_count), TIME_W'(want.update_count));
                check_field("destination_reached", TIME_W'(o_destination_reached),
                            TIME_W'(want.reached));
                check_field("raw_delta", o_raw_delta, want.raw_delta);
                check_field("frames_in_period", TIME_W'(o_frames_in_period),
                            TIME_W'(want.frames));
                check_field("is_active", TIME_W'(o_is_active), TIME_W'(want.is_active));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: draw a wait after every accepted result, and hold
    // off for a long stretch whenever a pressure request comes in.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int unsigned w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_wait  <= 0;
            hold_left   <= 0;
        end else if (pressure_req != pressure_ack) begin
            pressure_ack <= pressure_req;
            hold_left    <= HOLD_CYCLES;
            i_out_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!i_out_ready) begin
            if (ready_wait == 0)
                i_out_ready <= 1'b1;
            else
                ready_wait <= ready_wait - 1;
        end else if (o_out_valid) begin
            // a result went through at this edge: pick the next wait
            w = idle_off ? 0 : $urandom_range(0, 10);
            if (w != 0) begin
                i_out_ready <= 1'b0;
                ready_wait  <= w - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no handshake of any kind happens for too long.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request and register channels
    // ------------------------------------------------------------------

    // Offer one frame-start request after a random gap; keep valid high
    // across back-to-back requests so it never drops within one step.
    task automatic send_frame(input logic [TIME_W-1:0] ts);
        int unsigned gap;
        gap = idle_off ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_timestamp <= ts;
        ts_now = ts;
        do @(posedge i_clk); while (!o_in_ready);
        expected_frames.insert(expected_frames.size(), predict_frame(ts));
    endtask

    // Drop the request valid and wait until every result is back, then let
    // the pipeline settle before touching registers.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write one register and mirror it in the shadow copy.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FIXED_MODE: reg_fixed  = data[0];
            CFG_PERIOD:     reg_period = data[PERIOD_W-1:0];
            CFG_TARGET:     reg_target = data[TARGET_W-1:0];
            CFG_CYCLIC:     reg_cyclic = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all four registers; unused high data bits carry noise.
    task automatic configure(input logic fixed, input logic [PERIOD_W-1:0] period,
                             input logic [TARGET_W-1:0] target, input logic cyc);
        write_reg(CFG_FIXED_MODE, (CFG_DATA_W'(rand48()) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(fixed));
        write_reg(CFG_PERIOD, (CFG_DATA_W'(rand48()) & ~CFG_DATA_W'(20'hF_FFFF))
                              | CFG_DATA_W'(period));
        write_reg(CFG_TARGET, CFG_DATA_W'(target));
        write_reg(CFG_CYCLIC, (CFG_DATA_W'(rand48()) & ~CFG_DATA_W'(1)) | CFG_DATA_W'(cyc));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at reset: first frame, catch-up, target hit, full-second step.
    task automatic test_reset_defaults();
        send_frame(48'd5000);
        send_frame(48'd5000 + 48'd16667);
        send_frame(48'd5000 + 48'd16667 + 48'd50001);
        send_frame(48'd5000 + 48'd1000000);
        send_frame(48'd5000 + 48'd4500000);
        send_frame(48'd5000 + 48'd4500000);
    endtask

    // Period floor (zero and just below 1000), the smallest and largest periods.
    task automatic test_period_extremes();
        wait_idle();
        configure(1'b1, 20'd0, 40'hFF_FFFF_FFFF, 1'b1);
        send_frame(ts_now + 48'd999999);          // most updates one frame can give
        wait_idle();
        write_reg(CFG_PERIOD, 40'hAB_CD00_03E7);  // 999 with noise above
        send_frame(ts_now + 48'd2500);
        wait_idle();
        write_reg(CFG_PERIOD, CFG_DATA_W'(1000000));
        send_frame(ts_now + 48'd999999);
        send_frame(ts_now + 48'd1);               // reaching one second clears
        wait_idle();
        write_reg(CFG_PERIOD, 40'hFF_FFFF_FFFF);
        send_frame(ts_now + 48'd5000);
    endtask

    // Variable mode: nothing due, one update and clear, full-second clear.
    task automatic test_variable_mode();
        wait_idle();
        configure(1'b0, 20'd16667, 40'hFF_FFFF_FFFF, 1'b1);
        send_frame(ts_now + 48'd10000);
        send_frame(ts_now + 48'd10000);
        send_frame(ts_now + 48'd1000000);
        send_frame(ts_now + 48'd16667);
    endtask

    // Zero and full-scale targets, time running backwards, time wrapping.
    task automatic test_target_and_wrap();
        wait_idle();
        configure(1'b1, 20'd16667, 40'd0, 1'b1);
        send_frame(ts_now + 48'd123);
        send_frame(ts_now);
        wait_idle();
        write_reg(CFG_TARGET, 40'hFF_FFFF_FFFF);
        send_frame(ts_now + 48'h00FF_FFFF_FFFE);  // one tick short of the target
        send_frame(ts_now + 48'd1);
        send_frame(ts_now - 48'd12345);           // backwards: huge wrapped delta
        send_frame(48'hFFFF_FFFF_FFF0);
        send_frame(48'h0000_0000_0010);
    endtask

    // Long period of near-second frames so the frame count passes 16 bits.
    task automatic test_frame_count_wrap();
        wait_idle();
        configure(1'b1, PERIOD_W'($urandom_range(1000, 1100)), 40'hFF_FFFF_FFFF, 1'b1);
        repeat (80) send_frame(ts_now + TIME_W'($urandom_range(900000, 998000)));
    endtask

    // Random settings per phase; two phases without gaps, one of them also under back-pressure.
    task automatic test_random_phases();
        int unsigned         pick;
        logic [PERIOD_W-1:0] period;
        logic [TARGET_W-1:0] target;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick < 8)      period = PERIOD_W'($urandom_range(1000, 60000));
            else if (pick < 9) period = PERIOD_W'($urandom_range(0, 999));
            else               period = PERIOD_W'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 6)      target = TARGET_W'($urandom_range(0, 3000000));
            else if (pick < 8) target = TARGET_W'($urandom_range(0, 200000));
            else               target = TARGET_W'(rand48());
            configure(1'($urandom), period, target, 1'b1);
            idle_off <= (p == 2 || p == 4);
            if (p == 4)
                pressure_req <= pressure_req + 1;  // receiver stalls, sender keeps going
            repeat (55) send_frame(next_timestamp());
        end
        wait_idle();
        idle_off <= 1'b0;
    endtask

    // One-shot timer: once the target is hit the timer stays inactive.
    task automatic test_inactive_timer();
        wait_idle();
        configure(1'($urandom), PERIOD_W'($urandom_range(1000, 40000)),
                  TARGET_W'($urandom_range(0, 500000)), 1'b0);
        repeat (30) send_frame(next_timestamp());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_period_extremes();
        test_variable_mode();
        test_target_and_wrap();
        test_frame_count_wrap();
        test_random_phases();
        test_inactive_timer();   // last: the timer cannot come back to life

        wait_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
